FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, disabled while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/dgd_pkg.sv
// ----------------------------------------------------------------------------
// dgd_pkg
// Types, register codes and helpers shared by the gate detector modules.
// ----------------------------------------------------------------------------
package dgd_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CNT_BITS   = 16;
	localparam int CFG_WIDTH  = 16;
	localparam int IDX_BITS   = 2;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CNT_BITS-1:0]   count_t;

	// Register indexes on the configuration port.
	localparam logic [IDX_BITS-1:0] CFG_DEBOUNCE_THRESHOLD = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_DEADZONE_TICKS     = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_BEEP_PERIOD_TICKS  = 2'd2;
	localparam logic [IDX_BITS-1:0] CFG_BEEP_TOGGLES       = 2'd3;

	localparam logic [3:0]  RST_DEBOUNCE_THRESHOLD = 4'd2;
	localparam logic [15:0] RST_DEADZONE_TICKS     = 16'd200;
	localparam logic [15:0] RST_BEEP_PERIOD_TICKS  = 16'd300;
	localparam logic [3:0]  RST_BEEP_TOGGLES       = 4'd5;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic [3:0]  debounce_threshold;
		logic [15:0] deadzone_ticks;
		logic [15:0] beep_period_ticks;
		logic [3:0]  beep_toggles;
	} cfg_t;

	typedef struct packed {
		logic req_type;
		logic sensor_level;
	} item_t;

	// One processing step, issued when the staged item moves to the result.
	typedef struct packed {
		logic tick;
		logic sample;
		logic level;
	} step_t;

	typedef struct packed {
		logic   filtered_level;
		logic   alarm_on;
		count_t event_total;
		logic   gate_event;
	} result_t;

	// Fit a 16-bit register value to the timer width: truncate or zero-extend.
	function automatic timer_t timer_load(logic [15:0] v);
		timer_t r;
		for (int i = 0; i < TIMER_BITS; i++) begin
			r[i] = (i < 16) ? v[i % 16] : 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/dgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// dgd_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module dgd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dgd_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [dgd_pkg::CFG_WIDTH-1:0]     cfg_data,
	output dgd_pkg::cfg_t                     cfg
);

	dgd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_threshold <= dgd_pkg::RST_DEBOUNCE_THRESHOLD;
			cfg_q.deadzone_ticks     <= dgd_pkg::RST_DEADZONE_TICKS;
			cfg_q.beep_period_ticks  <= dgd_pkg::RST_BEEP_PERIOD_TICKS;
			cfg_q.beep_toggles       <= dgd_pkg::RST_BEEP_TOGGLES;
		end else if (cfg_we) begin
			case (cfg_index)
				dgd_pkg::CFG_DEBOUNCE_THRESHOLD: cfg_q.debounce_threshold <= cfg_data[3:0];
				dgd_pkg::CFG_DEADZONE_TICKS:     cfg_q.deadzone_ticks     <= cfg_data[15:0];
				dgd_pkg::CFG_BEEP_PERIOD_TICKS:  cfg_q.beep_period_ticks  <= cfg_data[15:0];
				dgd_pkg::CFG_BEEP_TOGGLES:       cfg_q.beep_toggles       <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/dgd_debounce.sv
// ----------------------------------------------------------------------------
// dgd_debounce
// Sample debouncer with the event lock; flags a new gate event.
// ----------------------------------------------------------------------------
module dgd_debounce (
	input  logic           clk,
	input  logic           arst_n,
	input  dgd_pkg::step_t step,
	input  logic [3:0]     threshold,
	input  logic           deadzone_idle,
	output logic           gate_event,
	output logic           stable_d
);

	logic [3:0] mismatch_q;
	logic       stable_q;
	logic       lock_q;

	logic [3:0] mismatch_d;
	logic [3:0] mismatch_inc;
	logic       lock_d;
	logic       ev;

	always_comb begin
		mismatch_inc = mismatch_q + 4'd1;
		mismatch_d   = mismatch_q;
		stable_d     = stable_q;
		lock_d       = lock_q;
		ev           = 1'b0;
		if (step.sample) begin
			if (step.level != stable_q) begin
				if (mismatch_inc >= threshold) begin
					stable_d   = step.level;
					mismatch_d = 4'd0;
					ev         = !step.level && !lock_q && deadzone_idle;
				end else begin
					mismatch_d = mismatch_inc;
				end
			end else begin
				mismatch_d = 4'd0;
			end
			// The lock holds only while the debounced level stays active.
			lock_d = (lock_q || ev) && !stable_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q <= 4'd0;
			stable_q   <= 1'b1;
			lock_q     <= 1'b0;
		end else begin
			mismatch_q <= mismatch_d;
			stable_q   <= stable_d;
			lock_q     <= lock_d;
		end
	end

	assign gate_event = ev;

endmodule

FILE: rtl/core/dgd_alarm.sv
// ----------------------------------------------------------------------------
// dgd_alarm
// Dead-zone timer, alarm toggle sequencer and the gate event counter.
// ----------------------------------------------------------------------------
module dgd_alarm (
	input  logic             clk,
	input  logic             arst_n,
	input  dgd_pkg::step_t   step,
	input  dgd_pkg::cfg_t    cfg,
	input  logic             gate_event,
	output logic             deadzone_idle,
	output logic             alarm_d,
	output dgd_pkg::count_t  total_d
);

	dgd_pkg::timer_t deadzone_q;
	dgd_pkg::timer_t period_q;
	logic [3:0]      toggles_q;
	logic            active_q;
	logic            alarm_q;
	dgd_pkg::count_t total_q;

	dgd_pkg::timer_t deadzone_d;
	dgd_pkg::timer_t period_d;
	logic [3:0]      toggles_d;
	logic            active_d;

	assign deadzone_idle = (deadzone_q == '0);

	always_comb begin
		deadzone_d = deadzone_q;
		period_d   = period_q;
		toggles_d  = toggles_q;
		active_d   = active_q;
		alarm_d    = alarm_q;
		total_d    = total_q;
		if (step.tick) begin
			if (!deadzone_idle) begin
				deadzone_d = deadzone_q - dgd_pkg::timer_t'(1);
			end
			if (active_q) begin
				if (period_q != '0) begin
					period_d = period_q - dgd_pkg::timer_t'(1);
				end else if (toggles_q != 4'd0) begin
					toggles_d = toggles_q - 4'd1;
					alarm_d   = !alarm_q;
					period_d  = dgd_pkg::timer_load(cfg.beep_period_ticks);
				end else begin
					active_d = 1'b0;
					alarm_d  = 1'b0;
				end
			end
		end else if (gate_event) begin
			// A new event restarts the alarm pattern from its beginning.
			total_d    = total_q + dgd_pkg::count_t'(1);
			toggles_d  = cfg.beep_toggles;
			period_d   = dgd_pkg::timer_load(cfg.beep_period_ticks);
			active_d   = 1'b1;
			alarm_d    = 1'b1;
			deadzone_d = dgd_pkg::timer_load(cfg.deadzone_ticks);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= '0;
			period_q   <= '0;
			toggles_q  <= 4'd0;
			active_q   <= 1'b0;
			alarm_q    <= 1'b0;
			total_q    <= '0;
		end else begin
			deadzone_q <= deadzone_d;
			period_q   <= period_d;
			toggles_q  <= toggles_d;
			active_q   <= active_d;
			alarm_q    <= alarm_d;
			total_q    <= total_d;
		end
	end

endmodule

FILE: rtl/core/debounced_gate_detector_with_alarm_core.sv
// ----------------------------------------------------------------------------
// debounced_gate_detector_with_alarm_core
// Debounced gate detector with event counter, dead-zone lockout and alarm.
// ----------------------------------------------------------------------------
// Each input transaction is a timer tick (tuser 0) or a sensor sample
// (tuser 1, level in tdata bit 0) and yields exactly one result transaction
// carrying the gate event flag, the 16-bit event total, the alarm output and
// the debounced level as they stand after that item. An item is registered on
// acceptance and is processed into the result register once that is free;
// the state update is a single pass of small decrement and compare logic, so
// the block sustains one item per cycle while the result side is ready.
// Back-pressure on the result side stalls the staged item; input is still
// taken while the result waits as long as the staging register is empty.
// Configuration must be written only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module debounced_gate_detector_with_alarm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] sensor_level, [7:1] zero
	input  logic                          s_tuser,   // [0] req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // [0] gate_event, [16:1] event_total,
	                                                 // [17] alarm_on, [18] filtered_level,
	                                                 // [23:19] zero
	input  logic                          cfg_we,
	input  logic [dgd_pkg::IDX_BITS-1:0]  cfg_index,
	input  logic [dgd_pkg::CFG_WIDTH-1:0] cfg_data
);

	dgd_pkg::cfg_t    cfg;
	dgd_pkg::item_t   item_s1;
	logic             valid_s1;
	dgd_pkg::result_t res_s2;
	logic             valid_s2;

	dgd_pkg::step_t   step;
	dgd_pkg::count_t  total_d;
	logic             fire;
	logic             ev;
	logic             deadzone_idle;
	logic             alarm_d;
	logic             stable_d;

	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type     <= s_tuser;
			item_s1.sensor_level <= s_tdata[0];
		end
	end

	always_comb begin
		step.tick   = fire && (item_s1.req_type == dgd_pkg::REQ_TICK);
		step.sample = fire && (item_s1.req_type == dgd_pkg::REQ_SAMPLE);
		step.level  = item_s1.sensor_level;
	end

	dgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dgd_debounce u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.threshold     (cfg.debounce_threshold),
		.deadzone_idle (deadzone_idle),
		.gate_event    (ev),
		.stable_d      (stable_d)
	);

	dgd_alarm u_alarm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cfg           (cfg),
		.gate_event    (ev),
		.deadzone_idle (deadzone_idle),
		.alarm_d       (alarm_d),
		.total_d       (total_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// The event total is reset with control state so that it always mirrors
	// the counter as of the last processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (fire) begin
			res_s2.gate_event     <= ev;
			res_s2.event_total    <= total_d;
			res_s2.alarm_on       <= alarm_d;
			res_s2.filtered_level <= stable_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2};

	// A reported event always comes with the alarm on and the level active.
	`ASSERT_CLK(a_event_alarm, valid_s2 && res_s2.gate_event |-> res_s2.alarm_on && !res_s2.filtered_level, "gate event without alarm on and active level")

	// A staged item that cannot move on is kept unchanged.
	`ASSERT_CLK(a_stall_hold, valid_s1 && !fire |=> valid_s1 && $stable(item_s1), "staged item lost or changed while stalled")

	// The event total only moves on an item that registers an event.
	`ASSERT_CLK(a_total_hold, fire && !ev |=> res_s2.event_total == $past(res_s2.event_total), "event total changed without a gate event")

	// Nothing is presented at the output while in reset.
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

FILE: tb/sv/debounced_gate_detector_with_alarm_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_gate_detector_with_alarm_core_tb
// Self-checking testbench for the debounced gate detector core.
// ----------------------------------------------------------------------------
// A table of directed transactions runs first. It covers reset values, ticks
// with both sensor levels, the debounce count, a zero threshold, a zero period
// and an event that restarts a running alarm. Random phases follow, each under
// its own register setting, with minimum and maximum values among them. Random
// items are runs of equal samples around the debounce threshold, tick bursts and
// noise. Every result is checked field by field against the table or a cycle-free
// model of the gate state. Both sides idle at random but in the last two phases;
// the receiver holds off once for a long stretch so that the core back-pressures.
// ----------------------------------------------------------------------------
module debounced_gate_detector_with_alarm_core_tb;

	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 250;
	localparam int NUM_PHASES   = 6;
	localparam int HOLD_CYCLES  = 64;
	localparam int HOLD_TRIGGER = 120;

	typedef enum logic [1:0] {
		ROW_CHECKED,
		ROW_TYPED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                        kind;
		logic [dgd_pkg::IDX_BITS-1:0]     idx;
		logic [dgd_pkg::CFG_WIDTH-1:0]    val;
		logic                             req;
		logic                             lvl;
		dgd_pkg::result_t                 want;
	} stim_row_t;

	// Fields from the top: filtered_level, alarm_on, event_total, gate_event.
	localparam dgd_pkg::result_t AT_RESET    = '{1'b1, 1'b0, 16'd0, 1'b0};
	localparam dgd_pkg::result_t FIRST_EVENT = '{1'b0, 1'b1, 16'd1, 1'b1};

	localparam int STIM_ROWS = 21;
	localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_TICK,   1'b0, AT_RESET},
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_TICK,   1'b1, AT_RESET},
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_SAMPLE, 1'b1, AT_RESET},
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_SAMPLE, 1'b0, AT_RESET},
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_SAMPLE, 1'b1, AT_RESET},
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_SAMPLE, 1'b0, AT_RESET},
		'{ROW_CFG, dgd_pkg::CFG_DEBOUNCE_THRESHOLD, 16'd0, dgd_pkg::REQ_TICK, 1'b0, '0},
		'{ROW_CFG, dgd_pkg::CFG_DEADZONE_TICKS,     16'd0, dgd_pkg::REQ_TICK, 1'b0, '0},
		'{ROW_CFG, dgd_pkg::CFG_BEEP_PERIOD_TICKS,  16'd0, dgd_pkg::REQ_TICK, 1'b0, '0},
		'{ROW_CFG, dgd_pkg::CFG_BEEP_TOGGLES,       16'd2, dgd_pkg::REQ_TICK, 1'b0, '0},
		'{ROW_TYPED,   '0, '0, dgd_pkg::REQ_SAMPLE, 1'b0, FIRST_EVENT},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_TICK,   1'b1, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_TICK,   1'b0, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_TICK,   1'b1, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_TICK,   1'b0, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_SAMPLE, 1'b0, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_SAMPLE, 1'b1, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_SAMPLE, 1'b0, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_TICK,   1'b0, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_SAMPLE, 1'b1, '0},
		'{ROW_CHECKED, '0, '0, dgd_pkg::REQ_SAMPLE, 1'b0, '0}
	};

	// Phase 4 is drawn at run time; the last phase holds every register at its top.
	localparam dgd_pkg::cfg_t PHASE_CFG [NUM_PHASES] = '{
		'{4'd2,  16'd5,     16'd2,     4'd3},
		'{4'd1,  16'd0,     16'd0,     4'd0},
		'{4'd0,  16'd12,    16'd1,     4'd15},
		'{4'd3,  16'd30,    16'd4,     4'd7},
		'{4'd2,  16'd8,     16'd3,     4'd2},
		'{4'd15, 16'd65535, 16'd65535, 4'd15}
	};

	typedef struct packed {
		logic [3:0]       mismatches;
		logic             stable;
		logic             locked;
		dgd_pkg::timer_t  dead_left;
		dgd_pkg::timer_t  period_left;
		logic [3:0]       toggles_left;
		logic             alarm_running;
		logic             alarm_out;
		dgd_pkg::count_t  total;
	} gate_state_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata   = '0;
	logic                          s_tuser   = dgd_pkg::REQ_TICK;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [23:0]                   m_tdata;
	logic                          cfg_we    = 1'b0;
	logic [dgd_pkg::IDX_BITS-1:0]  cfg_index = dgd_pkg::CFG_DEBOUNCE_THRESHOLD;
	logic [dgd_pkg::CFG_WIDTH-1:0] cfg_data  = '0;

	gate_state_t      gate_st;
	dgd_pkg::cfg_t    settings;
	dgd_pkg::result_t gate_results [$];
	dgd_pkg::result_t seen;
	dgd_pkg::result_t oldest;
	int               errors      = 0;
	int               items_sent  = 0;
	int               tx_idle_pct = 0;
	int               rx_idle_pct = 0;
	int               hold_left   = 0;
	bit               hold_done   = 1'b0;
	int               quiet       = 0;

	debounced_gate_detector_with_alarm_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advances the gate state by one item and returns what the core should report.
	function automatic dgd_pkg::result_t predict_gate(input logic req, input logic lvl);
		logic hit;
		hit = 1'b0;
		if (req == dgd_pkg::REQ_TICK) begin
			if (gate_st.dead_left != '0) gate_st.dead_left = gate_st.dead_left - 1'b1;
			if (gate_st.alarm_running) begin
				if (gate_st.period_left != '0) begin
					gate_st.period_left = gate_st.period_left - 1'b1;
				end else if (gate_st.toggles_left != '0) begin
					gate_st.toggles_left = gate_st.toggles_left - 1'b1;
					gate_st.alarm_out    = ~gate_st.alarm_out;
					gate_st.period_left  = settings.beep_period_ticks;
				end else begin
					gate_st.alarm_running = 1'b0;
					gate_st.alarm_out     = 1'b0;
				end
			end
		end else begin
			if (lvl != gate_st.stable) begin
				gate_st.mismatches = gate_st.mismatches + 4'd1;
				if (gate_st.mismatches >= settings.debounce_threshold) begin
					gate_st.stable     = lvl;
					gate_st.mismatches = '0;
					// A new low level is an event unless locked out or in the dead zone.
					if (!lvl && !gate_st.locked && gate_st.dead_left == '0) begin
						hit                   = 1'b1;
						gate_st.locked        = 1'b1;
						gate_st.total         = gate_st.total + 1'b1;
						gate_st.toggles_left  = settings.beep_toggles;
						gate_st.period_left   = settings.beep_period_ticks;
						gate_st.alarm_running = 1'b1;
						gate_st.alarm_out     = 1'b1;
						gate_st.dead_left     = settings.deadzone_ticks;
					end
				end
			end else begin
				gate_st.mismatches = '0;
			end
			if (gate_st.stable) gate_st.locked = 1'b0;
		end
		return '{gate_st.stable, gate_st.alarm_out, gate_st.total, hit};
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
		end
	endfunction

	// Called at a clock edge; leaves cfg_we high so that writes can follow back to back.
	task automatic write_register(input logic [dgd_pkg::IDX_BITS-1:0] idx,
			input logic [dgd_pkg::CFG_WIDTH-1:0] val);
		s_tvalid <= 1'b0;
		while (gate_results.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			dgd_pkg::CFG_DEBOUNCE_THRESHOLD: settings.debounce_threshold = val[3:0];
			dgd_pkg::CFG_DEADZONE_TICKS:     settings.deadzone_ticks     = val;
			dgd_pkg::CFG_BEEP_PERIOD_TICKS:  settings.beep_period_ticks  = val;
			dgd_pkg::CFG_BEEP_TOGGLES:       settings.beep_toggles       = val[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input dgd_pkg::cfg_t c);
		// The 4-bit registers get random upper bits, which the core must drop.
		write_register(dgd_pkg::CFG_DEBOUNCE_THRESHOLD, {12'($urandom), c.debounce_threshold});
		write_register(dgd_pkg::CFG_DEADZONE_TICKS, c.deadzone_ticks);
		write_register(dgd_pkg::CFG_BEEP_PERIOD_TICKS, c.beep_period_ticks);
		write_register(dgd_pkg::CFG_BEEP_TOGGLES, {12'($urandom), c.beep_toggles});
	endtask

	task automatic send_item(input logic req, input logic lvl, input logic typed,
			input dgd_pkg::result_t want);
		dgd_pkg::result_t pred;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {7'b0, lvl};
		do @(posedge clk); while (!s_tready);
		pred = predict_gate(req, lvl);
		gate_results.push_back(typed ? want : pred);
		items_sent++;
	endtask

	initial begin
		int            left;
		int            run_len;
		int            seg;
		logic          run_lvl;
		dgd_pkg::cfg_t ph;

		// Driving reset low from the unknown start gives the core a reset edge.
		arst_n <= 1'b0;
		gate_st  = '{4'd0, 1'b1, 1'b0, '0, '0, 4'd0, 1'b0, 1'b0, '0};
		settings = '{dgd_pkg::RST_DEBOUNCE_THRESHOLD, dgd_pkg::RST_DEADZONE_TICKS,
			dgd_pkg::RST_BEEP_PERIOD_TICKS, dgd_pkg::RST_BEEP_TOGGLES};
		run_lvl  = 1'b1;
		tx_idle_pct = 14;
		rx_idle_pct = 55;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < STIM_ROWS; r++) begin
			case (STIM_TABLE[r].kind)
				ROW_CFG: begin
					write_register(STIM_TABLE[r].idx, STIM_TABLE[r].val);
				end
				ROW_TYPED: begin
					send_item(STIM_TABLE[r].req, STIM_TABLE[r].lvl, 1'b1, STIM_TABLE[r].want);
				end
				default: begin
					send_item(STIM_TABLE[r].req, STIM_TABLE[r].lvl, 1'b0, '0);
				end
			endcase
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 2)
				0: begin
					tx_idle_pct = 14;
					rx_idle_pct = 55;
				end
				1: begin
					tx_idle_pct = 55;
					rx_idle_pct = 14;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			ph = PHASE_CFG[p];
			if (p == 4) begin
				ph = '{4'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
					16'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
			end
			apply_settings(ph);

			left = PHASE_ITEMS;
			while (left > 0) begin
				seg = $urandom_range(0, 9);
				if (seg < 4) begin
					// Tick burst, which counts dead zones and alarm periods down.
					run_len = $urandom_range(1, 12);
					for (int k = 0; k < run_len && left > 0; k++) begin
						send_item(dgd_pkg::REQ_TICK, 1'($urandom), 1'b0, '0);
						left--;
					end
				end else if (seg < 9) begin
					// A run of equal samples, sometimes shorter than the threshold.
					if ($urandom_range(0, 3) != 0) run_lvl = ~run_lvl;
					run_len = $urandom_range(1, settings.debounce_threshold + 2);
					for (int k = 0; k < run_len && left > 0; k++) begin
						send_item(dgd_pkg::REQ_SAMPLE, run_lvl, 1'b0, '0);
						left--;
					end
				end else begin
					run_len = $urandom_range(1, 4);
					for (int k = 0; k < run_len && left > 0; k++) begin
						send_item(dgd_pkg::REQ_SAMPLE, 1'($urandom), 1'b0, '0);
						left--;
					end
				end
			end
		end

		s_tvalid <= 1'b0;
		cfg_we   <= 1'b0;
		while (gate_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Result side ready, with one long hold-off that lets the core fill up.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && items_sent >= HOLD_TRIGGER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[18:0];
			if (gate_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
			end else begin
				oldest = gate_results.pop_front();
				check_field("gate_event", oldest.gate_event, seen.gate_event);
				check_field("event_total", oldest.event_total, seen.event_total);
				check_field("alarm_on", oldest.alarm_on, seen.alarm_on);
				check_field("filtered_level", oldest.filtered_level, seen.filtered_level);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet = quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dgd_pkg.sv
rtl/core/dgd_cfg_regs.sv
rtl/core/dgd_debounce.sv
rtl/core/dgd_alarm.sv
rtl/core/debounced_gate_detector_with_alarm_core.sv
tb/sv/debounced_gate_detector_with_alarm_core_tb.sv
